FILE: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared types, codes and helpers of the priority process scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int SLOT_W          = 6;
  localparam int PRIO_W          = 7;
  localparam int CNT_W           = 32;
  localparam int IN_W            = 24;
  localparam int OUT_W           = 144;

  localparam logic [PRIO_W-1:0] PRIO_MAX   = 7'd100;
  localparam logic [PRIO_W-1:0] PRIO_RESET = 7'd60;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 32'hFFFF_FFFF;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd4;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SELECT = 3'd1;
  localparam logic [2:0] OP_ALLOC  = 3'd2;
  localparam logic [2:0] OP_SETST  = 3'd3;
  localparam logic [2:0] OP_SETPR  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  typedef struct packed {
    logic [2:0]        status;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  run_time;
    logic [CNT_W-1:0]  wait_cnt;
    logic [CNT_W-1:0]  total_wait;
    logic [CNT_W-1:0]  runs;
  } slot_rec_t;

  typedef struct packed {
    logic status;
    logic prio;
    logic run_time;
    logic wait_cnt;
    logic total_wait;
    logic runs;
  } slot_we_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] v);
    clamp_prio = (v > PRIO_MAX) ? PRIO_MAX : v;
  endfunction

endpackage

FILE: rtl/pps_slot_mem.sv
// ----------------------------------------------------------------------------
// pps_slot_mem
// slot table storage: one write port, one registered read port
// ----------------------------------------------------------------------------
module pps_slot_mem #(
  parameter int SLOTS = pps_pkg::TABLE_SLOTS_DEF
) (
  input  logic                  clk,
  input  pps_pkg::slot_we_t     we,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  pps_pkg::slot_rec_t    wdata,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output pps_pkg::slot_rec_t    rd_data
);

  logic [2:0]                    status_mem [SLOTS];
  logic [pps_pkg::PRIO_W-1:0]    prio_mem   [SLOTS];
  logic [pps_pkg::CNT_W-1:0]     run_mem    [SLOTS];
  logic [pps_pkg::CNT_W-1:0]     wait_mem   [SLOTS];
  logic [pps_pkg::CNT_W-1:0]     total_mem  [SLOTS];
  logic [pps_pkg::CNT_W-1:0]     runs_mem   [SLOTS];

  always_ff @(posedge clk) begin
    if (we.status) begin
      status_mem[wr_addr] <= wdata.status;
    end
    if (we.prio) begin
      prio_mem[wr_addr] <= wdata.prio;
    end
    if (we.run_time) begin
      run_mem[wr_addr] <= wdata.run_time;
    end
    if (we.wait_cnt) begin
      wait_mem[wr_addr] <= wdata.wait_cnt;
    end
    if (we.total_wait) begin
      total_mem[wr_addr] <= wdata.total_wait;
    end
    if (we.runs) begin
      runs_mem[wr_addr] <= wdata.runs;
    end
    rd_data.status     <= status_mem[rd_addr];
    rd_data.prio       <= prio_mem[rd_addr];
    rd_data.run_time   <= run_mem[rd_addr];
    rd_data.wait_cnt   <= wait_mem[rd_addr];
    rd_data.total_wait <= total_mem[rd_addr];
    rd_data.runs       <= runs_mem[rd_addr];
  end

endmodule

FILE: rtl/priority_process_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_process_scheduler_unit
// static priority scheduler over a slot table, one slot visited per cycle
// work per item: tick and alloc scan the table, select scans and then fetches
//   the chosen slot, set status / set priority / read fetch their slot (slot
//   table read port), slot out of the table or unknown op go straight to the result
// one item at a time: the next item is taken the cycle after the result loads
// reset: status clearing pass over every slot, in_tready low meanwhile
// ----------------------------------------------------------------------------
module priority_process_scheduler_unit #(
  parameter int TABLE_SLOTS = pps_pkg::TABLE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pps_pkg::PRIO_W-1:0]  cfg_data,   // default_priority
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pps_pkg::IN_W-1:0]    in_tdata,   // op, slot, priority_value, new_status
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // ok, chosen_slot, prev_prio, reschedule, run_time, current_wait,
  // total_wait, run_count
  output logic [pps_pkg::OUT_W-1:0]   out_tdata
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_RESULT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                cnt_r, cnt_nxt;
  logic                         last_r, last_nxt;
  logic                         proc_vld_r, proc_vld_nxt;
  logic [AW-1:0]                proc_idx_r, proc_idx_nxt;
  logic [2:0]                   op_r, op_nxt;
  logic [pps_pkg::PRIO_W-1:0]   pv_r, pv_nxt;
  logic [1:0]                   ns_r, ns_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic                         hit_r, hit_nxt;
  logic [pps_pkg::PRIO_W-1:0]   best_prio_r, best_prio_nxt;
  logic [pps_pkg::CNT_W-1:0]    best_wait_r, best_wait_nxt;
  logic [pps_pkg::PRIO_W-1:0]   dflt_r, dflt_nxt;

  logic                         out_tvalid_r, out_tvalid_nxt;
  logic                         out_ok_r, out_ok_nxt;
  logic [pps_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [pps_pkg::PRIO_W-1:0]   out_oldp_r, out_oldp_nxt;
  logic                         out_resch_r, out_resch_nxt;
  logic [pps_pkg::CNT_W-1:0]    out_run_r, out_run_nxt;
  logic [pps_pkg::CNT_W-1:0]    out_wait_r, out_wait_nxt;
  logic [pps_pkg::CNT_W-1:0]    out_total_r, out_total_nxt;
  logic [pps_pkg::CNT_W-1:0]    out_runs_r, out_runs_nxt;

  pps_pkg::slot_we_t            mem_we;
  pps_pkg::slot_rec_t           mem_wdata;
  pps_pkg::slot_rec_t           rd_q;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;

  logic [2:0]                   in_op;
  logic [pps_pkg::SLOT_W-1:0]   in_slot;
  logic [pps_pkg::PRIO_W-1:0]   in_pv;
  logic [1:0]                   in_ns;
  logic                         in_table;
  logic                         out_free;
  logic                         better;
  logic                         slot_live;

  assign in_op    = in_tdata[2:0];
  assign in_slot  = in_tdata[8:3];
  assign in_pv    = in_tdata[15:9];
  assign in_ns    = in_tdata[17:16];
  assign in_table = int'(in_slot) < TABLE_SLOTS;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_runs_r, out_total_r, out_wait_r, out_run_r,
                       out_resch_r, out_oldp_r, out_slot_r, out_ok_r};

  assign out_free  = !out_tvalid_r || out_tready;
  assign better    = !hit_r || (rd_q.prio < best_prio_r) ||
                     ((rd_q.prio == best_prio_r) && (rd_q.wait_cnt > best_wait_r));
  assign slot_live = hit_r && (rd_q.status != pps_pkg::ST_UNUSED);

  pps_slot_mem #(
    .SLOTS (TABLE_SLOTS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (wr_addr),
    .wdata   (mem_wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    proc_vld_nxt   = proc_vld_r;
    proc_idx_nxt   = proc_idx_r;
    op_nxt         = op_r;
    pv_nxt         = pv_r;
    ns_nxt         = ns_r;
    addr_nxt       = addr_r;
    hit_nxt        = hit_r;
    best_prio_nxt  = best_prio_r;
    best_wait_nxt  = best_wait_r;
    dflt_nxt       = dflt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_ok_nxt     = out_ok_r;
    out_slot_nxt   = out_slot_r;
    out_oldp_nxt   = out_oldp_r;
    out_resch_nxt  = out_resch_r;
    out_run_nxt    = out_run_r;
    out_wait_nxt   = out_wait_r;
    out_total_nxt  = out_total_r;
    out_runs_nxt   = out_runs_r;
    mem_we         = '0;
    mem_wdata      = '0;
    wr_addr        = addr_r;
    rd_addr        = addr_r;

    if (cfg_valid) begin
      dflt_nxt = cfg_data;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_addr          = cnt_r;
        mem_we.status    = 1'b1;
        mem_wdata.status = pps_pkg::ST_UNUSED;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_op;
          pv_nxt       = pps_pkg::clamp_prio(in_pv);
          ns_nxt       = in_ns;
          cnt_nxt      = '0;
          last_nxt     = 1'b0;
          proc_vld_nxt = 1'b0;
          case (in_op) inside
            pps_pkg::OP_TICK: begin
              hit_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end
            pps_pkg::OP_SELECT, pps_pkg::OP_ALLOC: begin
              hit_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
            pps_pkg::OP_SETST, pps_pkg::OP_SETPR, pps_pkg::OP_READ: begin
              addr_nxt  = AW'(in_slot);
              hit_nxt   = in_table;
              state_nxt = in_table ? S_FETCH : S_RESULT;
            end
            default: begin
              hit_nxt   = 1'b0;
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = cnt_r;
        if (!last_r) begin
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = cnt_r;
          if (cnt_r == LAST_IDX) begin
            last_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          proc_vld_nxt = 1'b0;
        end
        if (proc_vld_r) begin
          wr_addr = proc_idx_r;
          case (op_r)
            pps_pkg::OP_TICK: begin
              if (rd_q.status == pps_pkg::ST_RUNNING) begin
                mem_we.run_time    = 1'b1;
                mem_wdata.run_time = pps_pkg::sat_inc(rd_q.run_time);
              end else if (rd_q.status == pps_pkg::ST_RUNNABLE) begin
                mem_we.wait_cnt      = 1'b1;
                mem_we.total_wait    = 1'b1;
                mem_wdata.wait_cnt   = pps_pkg::sat_inc(rd_q.wait_cnt);
                mem_wdata.total_wait = pps_pkg::sat_inc(rd_q.total_wait);
              end
            end
            pps_pkg::OP_SELECT: begin
              if (rd_q.status == pps_pkg::ST_RUNNABLE && better) begin
                hit_nxt       = 1'b1;
                addr_nxt      = proc_idx_r;
                best_prio_nxt = rd_q.prio;
                best_wait_nxt = rd_q.wait_cnt;
              end
            end
            pps_pkg::OP_ALLOC: begin
              if (rd_q.status == pps_pkg::ST_UNUSED && !hit_r) begin
                hit_nxt  = 1'b1;
                addr_nxt = proc_idx_r;
              end
            end
            default: begin
            end
          endcase
        end
        if (last_r) begin
          state_nxt = (op_r == pps_pkg::OP_SELECT && hit_nxt) ? S_FETCH : S_RESULT;
        end
      end
      S_FETCH: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b1;
          out_ok_nxt     = 1'b0;
          out_slot_nxt   = '0;
          out_oldp_nxt   = '0;
          out_resch_nxt  = 1'b0;
          out_run_nxt    = '0;
          out_wait_nxt   = '0;
          out_total_nxt  = '0;
          out_runs_nxt   = '0;
          case (op_r) inside
            pps_pkg::OP_TICK: begin
              out_ok_nxt = 1'b1;
            end
            pps_pkg::OP_SELECT: begin
              if (hit_r) begin
                mem_we.status      = 1'b1;
                mem_we.wait_cnt    = 1'b1;
                mem_we.runs        = 1'b1;
                mem_wdata.status   = pps_pkg::ST_RUNNING;
                mem_wdata.wait_cnt = '0;
                mem_wdata.runs     = pps_pkg::sat_inc(rd_q.runs);
                out_ok_nxt         = 1'b1;
                out_slot_nxt       = pps_pkg::SLOT_W'(addr_r);
                out_oldp_nxt       = rd_q.prio;
                out_run_nxt        = rd_q.run_time;
                out_total_nxt      = rd_q.total_wait;
                out_runs_nxt       = pps_pkg::sat_inc(rd_q.runs);
              end
            end
            pps_pkg::OP_ALLOC: begin
              if (hit_r) begin
                mem_we               = '1;
                mem_wdata.status     = pps_pkg::ST_RUNNABLE;
                mem_wdata.prio       = pps_pkg::clamp_prio(dflt_r);
                mem_wdata.run_time   = '0;
                mem_wdata.wait_cnt   = '0;
                mem_wdata.total_wait = '0;
                mem_wdata.runs       = '0;
                out_ok_nxt           = 1'b1;
                out_slot_nxt         = pps_pkg::SLOT_W'(addr_r);
                out_oldp_nxt         = pps_pkg::clamp_prio(dflt_r);
              end
            end
            pps_pkg::OP_SETST, pps_pkg::OP_SETPR, pps_pkg::OP_READ: begin
              if ((op_r == pps_pkg::OP_SETST && hit_r) || slot_live) begin
                out_ok_nxt    = 1'b1;
                out_slot_nxt  = pps_pkg::SLOT_W'(addr_r);
                out_oldp_nxt  = rd_q.prio;
                out_run_nxt   = rd_q.run_time;
                out_wait_nxt  = rd_q.wait_cnt;
                out_total_nxt = rd_q.total_wait;
                out_runs_nxt  = rd_q.runs;
                if (op_r == pps_pkg::OP_SETST) begin
                  mem_we.status    = 1'b1;
                  mem_wdata.status = {1'b0, ns_r};
                end else if (op_r == pps_pkg::OP_SETPR) begin
                  mem_we.prio    = 1'b1;
                  mem_wdata.prio = pv_r;
                  out_resch_nxt  = rd_q.prio > pv_r;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      last_r       <= 1'b0;
      proc_vld_r   <= 1'b0;
      hit_r        <= 1'b0;
      dflt_r       <= pps_pkg::PRIO_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      last_r       <= last_nxt;
      proc_vld_r   <= proc_vld_nxt;
      hit_r        <= hit_nxt;
      dflt_r       <= dflt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    proc_idx_r  <= proc_idx_nxt;
    op_r        <= op_nxt;
    pv_r        <= pv_nxt;
    ns_r        <= ns_nxt;
    addr_r      <= addr_nxt;
    best_prio_r <= best_prio_nxt;
    best_wait_r <= best_wait_nxt;
    out_ok_r    <= out_ok_nxt;
    out_slot_r  <= out_slot_nxt;
    out_oldp_r  <= out_oldp_nxt;
    out_resch_r <= out_resch_nxt;
    out_run_r   <= out_run_nxt;
    out_wait_r  <= out_wait_nxt;
    out_total_r <= out_total_nxt;
    out_runs_r  <= out_runs_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready stayed high after an item was accepted");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_tvalid_r)
    else $error("result presented during the clearing pass");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[pps_pkg::OUT_W-1:1] == '0))
    else $error("failed item carries nonzero fields");
`endif

endmodule

FILE: tb/priority_process_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// priority_process_scheduler_unit_test
// drives table operations into the scheduler through the input stream and
// checks every result item field by field against a slot table kept in the
// bench or a result written in the directed row; a short directed list comes
// first, then random traffic over several default priority settings, with
// bursty input and a stalling result side
module priority_process_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = pps_pkg::TABLE_SLOTS_DEF;

  localparam logic [2:0] ST_SLEEPING = 3'd1;
  localparam logic [2:0] ST_ZOMBIE   = 3'd3;
  localparam logic [2:0] OP_BAD6     = 3'd6;
  localparam logic [2:0] OP_BAD7     = 3'd7;

  // fields from the highest bit down
  typedef struct packed {
    logic [5:0]                 pad;
    logic [1:0]                 nst;
    logic [pps_pkg::PRIO_W-1:0] prio;
    logic [pps_pkg::SLOT_W-1:0] slot;
    logic [2:0]                 op;
  } cmd_t;

  typedef struct packed {
    logic                       pad;
    logic [pps_pkg::CNT_W-1:0]  run_count;
    logic [pps_pkg::CNT_W-1:0]  total_wait;
    logic [pps_pkg::CNT_W-1:0]  cur_wait;
    logic [pps_pkg::CNT_W-1:0]  run_time;
    logic                       reschedule;
    logic [pps_pkg::PRIO_W-1:0] prev_prio;
    logic [pps_pkg::SLOT_W-1:0] chosen_slot;
    logic                       ok;
  } res_t;

  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t res;
  } row_t;

  logic                       clk;
  logic                       rst_n      = 1'b0;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [pps_pkg::PRIO_W-1:0] cfg_data   = '0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [pps_pkg::IN_W-1:0]   in_tdata   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [pps_pkg::OUT_W-1:0]  out_tdata;

  // slot table as the bench sees it
  logic [2:0]                 tbl_status[N];
  logic [pps_pkg::PRIO_W-1:0] tbl_prio[N];
  logic [pps_pkg::CNT_W-1:0]  tbl_run[N];
  logic [pps_pkg::CNT_W-1:0]  tbl_wait[N];
  logic [pps_pkg::CNT_W-1:0]  tbl_twait[N];
  logic [pps_pkg::CNT_W-1:0]  tbl_runs[N];
  bit                         tbl_touched[N];
  logic [pps_pkg::PRIO_W-1:0] dflt_prio;

  res_t        sched_expected[$];
  row_t        dir_rows[$];
  int          errors     = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned rx_cycle   = 0;
  string       fld[8] = '{"ok", "chosen_slot", "prev_prio", "reschedule",
                          "run_time", "current_wait", "total_wait", "run_count"};

  priority_process_scheduler_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [pps_pkg::CNT_W-1:0] bump(input logic [pps_pkg::CNT_W-1:0] v);
    return (v == pps_pkg::CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic res_t sched_predict(input cmd_t c);
    res_t                       r;
    int                         best;
    logic [pps_pkg::PRIO_W-1:0] pv;
    r = '0;
    best = -1;
    pv = (c.prio > pps_pkg::PRIO_MAX) ? pps_pkg::PRIO_MAX : c.prio;
    case (c.op)
      pps_pkg::OP_TICK: begin
        for (int i = 0; i < N; i++) begin
          if (tbl_status[i] == pps_pkg::ST_RUNNING) begin
            tbl_run[i] = bump(tbl_run[i]);
          end else if (tbl_status[i] == pps_pkg::ST_RUNNABLE) begin
            tbl_wait[i]  = bump(tbl_wait[i]);
            tbl_twait[i] = bump(tbl_twait[i]);
          end
        end
        r.ok = 1'b1;
      end
      pps_pkg::OP_SELECT: begin
        for (int i = 0; i < N; i++) begin
          if (tbl_status[i] == pps_pkg::ST_RUNNABLE &&
              (best < 0 || tbl_prio[i] < tbl_prio[best] ||
               (tbl_prio[i] == tbl_prio[best] && tbl_wait[i] > tbl_wait[best])))
            best = i;
        end
        if (best >= 0) begin
          tbl_status[best] = pps_pkg::ST_RUNNING;
          tbl_wait[best]   = '0;
          tbl_runs[best]   = bump(tbl_runs[best]);
        end
      end
      pps_pkg::OP_ALLOC: begin
        for (int i = 0; i < N; i++) begin
          if (best < 0 && tbl_status[i] == pps_pkg::ST_UNUSED) best = i;
        end
        if (best >= 0) begin
          tbl_status[best]  = pps_pkg::ST_RUNNABLE;
          tbl_prio[best]    = (dflt_prio > pps_pkg::PRIO_MAX) ? pps_pkg::PRIO_MAX : dflt_prio;
          tbl_run[best]     = '0;
          tbl_wait[best]    = '0;
          tbl_twait[best]   = '0;
          tbl_runs[best]    = '0;
          tbl_touched[best] = 1'b1;
        end
      end
      pps_pkg::OP_SETST: begin
        tbl_status[c.slot] = {1'b0, c.nst};
        best = c.slot;
      end
      pps_pkg::OP_SETPR: begin
        if (tbl_status[c.slot] != pps_pkg::ST_UNUSED) begin
          r.prev_prio  = tbl_prio[c.slot];
          r.reschedule = tbl_prio[c.slot] > pv;
          tbl_prio[c.slot] = pv;
          best = c.slot;
        end
      end
      pps_pkg::OP_READ: begin
        if (tbl_status[c.slot] != pps_pkg::ST_UNUSED) best = c.slot;
      end
      default: ;
    endcase
    if (best >= 0) begin
      r.ok          = 1'b1;
      r.chosen_slot = pps_pkg::SLOT_W'(best);
      if (c.op != pps_pkg::OP_SETPR) r.prev_prio = tbl_prio[best];
      r.run_time    = tbl_run[best];
      r.cur_wait    = tbl_wait[best];
      r.total_wait  = tbl_twait[best];
      r.run_count   = tbl_runs[best];
    end
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   touched[$];
    int   live[$];
    int   w;
    c = '0;
    c.slot = pps_pkg::SLOT_W'($urandom_range(0, N - 1));
    c.prio = pps_pkg::PRIO_W'($urandom_range(0, 127));
    c.nst  = 2'($urandom_range(0, 3));
    for (int i = 0; i < N; i++) begin
      if (tbl_touched[i]) touched.push_back(i);
      if (tbl_status[i] != pps_pkg::ST_UNUSED) live.push_back(i);
    end
    w = $urandom_range(0, 99);
    if (w < 25) c.op = pps_pkg::OP_TICK;
    else if (w < 45) c.op = pps_pkg::OP_SELECT;
    else if (w < 60) c.op = pps_pkg::OP_ALLOC;
    else if (w < 75) c.op = pps_pkg::OP_SETST;
    else if (w < 87) c.op = pps_pkg::OP_SETPR;
    else if (w < 97) c.op = pps_pkg::OP_READ;
    else c.op = w[0] ? OP_BAD7 : OP_BAD6;
    // status changes only on slots whose entries have been written
    if (c.op == pps_pkg::OP_SETST) begin
      if (touched.size() == 0) c.op = pps_pkg::OP_ALLOC;
      else c.slot = pps_pkg::SLOT_W'(touched[$urandom_range(0, touched.size() - 1)]);
    end else if ((c.op == pps_pkg::OP_SETPR || c.op == pps_pkg::OP_READ) &&
                 live.size() != 0 && $urandom_range(0, 4) != 0) begin
      c.slot = pps_pkg::SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    end
    return c;
  endfunction

  task automatic add_row(input logic [2:0] op, input int slot, input int pv,
                         input logic [2:0] nst, input int typed, input int ok,
                         input int cs, input int oprio);
    row_t row;
    row.cmd      = '0;
    row.cmd.op   = op;
    row.cmd.slot = pps_pkg::SLOT_W'(slot);
    row.cmd.prio = pps_pkg::PRIO_W'(pv);
    row.cmd.nst  = nst[1:0];
    row.typed    = (typed != 0);
    row.res      = '0;
    row.res.ok          = (ok != 0);
    row.res.chosen_slot = pps_pkg::SLOT_W'(cs);
    row.res.prev_prio   = pps_pkg::PRIO_W'(oprio);
    dir_rows.push_back(row);
  endtask

  task automatic send_cmd(input cmd_t c, input bit typed, input res_t typed_res,
                          output res_t pred);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pred = sched_predict(c);
    sched_expected.push_back(typed ? typed_res : pred);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sched_expected.size() != 0);
  endtask

  task automatic write_default_prio(input logic [pps_pkg::PRIO_W-1:0] v);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dflt_prio = v;
  endtask

  task automatic check_result(input res_t want, input res_t got);
    logic [31:0] w[8];
    logic [31:0] g[8];
    w = '{want.ok, want.chosen_slot, want.prev_prio, want.reschedule,
          want.run_time, want.cur_wait, want.total_wait, want.run_count};
    g = '{got.ok, got.chosen_slot, got.prev_prio, got.reschedule,
          got.run_time, got.cur_wait, got.total_wait, got.run_count};
    for (int k = 0; k < 8; k++) begin
      if (w[k] !== g[k]) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, fld[k], w[k], g[k]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sched_expected.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, actual %h", $time, out_tdata);
      end else begin
        check_result(sched_expected.pop_front(), out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_cycle[12:11] == 2'b11 || $urandom_range(0, 9) != 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= $urandom_range(1, 30);
      out_tready <= 1'b0;
    end
  end

  initial begin
    int   phase_dflt[5];
    res_t pred;
    cmd_t fill_cmd;
    for (int i = 0; i < N; i++) begin
      tbl_status[i]  = pps_pkg::ST_UNUSED;
      tbl_prio[i]    = '0;
      tbl_run[i]     = '0;
      tbl_wait[i]    = '0;
      tbl_twait[i]   = '0;
      tbl_runs[i]    = '0;
      tbl_touched[i] = 1'b0;
    end
    dflt_prio = pps_pkg::PRIO_RESET;
    fill_cmd = '0;
    fill_cmd.op = pps_pkg::OP_ALLOC;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_row(pps_pkg::OP_SELECT, 0, 0, pps_pkg::ST_UNUSED, 1, 0, 0, 0);
    add_row(pps_pkg::OP_READ, 0, 0, pps_pkg::ST_UNUSED, 1, 0, 0, 0);
    add_row(pps_pkg::OP_SETPR, 5, 10, pps_pkg::ST_UNUSED, 1, 0, 0, 0);
    add_row(OP_BAD6, 0, 0, pps_pkg::ST_UNUSED, 1, 0, 0, 0);
    add_row(OP_BAD7, 63, 127, ST_ZOMBIE, 1, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 42, 85, ST_SLEEPING, 1, 1, 0, 0);
    add_row(pps_pkg::OP_ALLOC, 0, 0, pps_pkg::ST_UNUSED, 1, 1, 0, pps_pkg::PRIO_RESET);
    add_row(pps_pkg::OP_ALLOC, 0, 0, pps_pkg::ST_UNUSED, 1, 1, 1, pps_pkg::PRIO_RESET);
    add_row(pps_pkg::OP_ALLOC, 0, 0, pps_pkg::ST_UNUSED, 1, 1, 2, pps_pkg::PRIO_RESET);
    add_row(pps_pkg::OP_TICK, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SETPR, 1, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SETPR, 2, 127, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SELECT, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SETPR, 2, 60, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SELECT, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SELECT, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SELECT, 0, 0, pps_pkg::ST_UNUSED, 1, 0, 0, 0);
    add_row(pps_pkg::OP_SETST, 0, 0, pps_pkg::ST_RUNNABLE, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SETST, 1, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_ALLOC, 0, 0, pps_pkg::ST_UNUSED, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SETST, 2, 0, ST_SLEEPING, 0, 0, 0, 0);
    add_row(pps_pkg::OP_SETST, 2, 0, ST_ZOMBIE, 0, 0, 0, 0);
    add_row(pps_pkg::OP_READ, 63, 0, pps_pkg::ST_UNUSED, 1, 0, 0, 0);
    foreach (dir_rows[k]) send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].res, pred);

    phase_dflt = '{0, 127, 100, $urandom_range(1, 126), 60};
    for (int p = 0; p < 5; p++) begin
      write_default_prio(pps_pkg::PRIO_W'(phase_dflt[p]));
      // in the first phase, fill the table until alloc fails
      if (p == 0) begin
        do send_cmd(fill_cmd, 1'b0, '0, pred); while (pred.ok);
      end
      repeat (70) begin
        if ($urandom_range(0, 39) == 0) hold_until_drained();
        send_cmd(random_cmd(), 1'b0, '0, pred);
      end
    end

    hold_until_drained();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("priority_process_scheduler_unit_test: done, clean");
    end else begin
      $display("priority_process_scheduler_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("priority_process_scheduler_unit_test: done, errors");
    $finish;
  end

endmodule
